// File: hw/rtl/bgce_pkg.sv
// Shared constants and types for the box-to-grid cell enumerator.
// Used by bgce_div and box_to_grid_cell_enumerator_core; no dependencies.
`default_nettype none
package bgce_pkg;

   // Field widths
   localparam int COORD_W  = 24;   // box corner coordinates, two's complement
   localparam int GRID_W   = 9;    // grid_size register
   localparam int SQ_W     = 16;   // square_size register
   localparam int IDX_W    = 16;   // linear cell index
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Limits
   localparam int MAX_SPAN = 8;
   localparam int MAX_GRID = 256;
   localparam int SPAN_W   = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
   localparam int CELL_W   = $clog2(MAX_GRID);   // in-grid row or column bits

   // Offset (grid_size/2)*square_size and the dividend/quotient widths
   localparam int HALF_W   = GRID_W - 1;
   localparam int OFF_W    = HALF_W + SQ_W;
   localparam int DVD_W    = COORD_W + 1;        // coordinate plus offset, signed
   localparam int MAG_W    = DVD_W - 1;          // magnitude fed to the divider
   localparam int CNT_W    = $clog2(MAG_W);

   // Register reset values
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);
   localparam logic [SQ_W-1:0]   SQ_RESET   = SQ_W'(32);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE_SIZE = CSR_IDX_W'(1);

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/bgce_div.sv
// Shared restoring divider: floor division of a signed dividend by an
// unsigned cell size, one quotient bit per cycle. Depends on bgce_pkg.
`default_nettype none
module bgce_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bgce_pkg::DVD_W-1:0]    dividend,
   input  wire logic [bgce_pkg::SQ_W-1:0]     divisor,
   output bgce_pkg::div_stat_type             stat,
   output logic      [bgce_pkg::DVD_W-1:0]    quotient
);
   import bgce_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [SQ_W-1:0]   dsr_ff, dsr_in;
   logic [SQ_W:0]     shifted;
   logic              ge;

   // floor(a/s) for a < 0 equals ~(~a / s): divide the complement, then invert
   always_comb begin
      shifted = {rem_ff, quo_ff[MAG_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DVD_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[DVD_W-1] ? ~dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? SQ_W'(shifted - {1'b0, dsr_ff}) : shifted[SQ_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = neg_ff ? ~{1'b0, quo_ff} : {1'b0, quo_ff};

endmodule
`default_nettype wire

// File: hw/rtl/box_to_grid_cell_enumerator_core.sv
// Box-to-grid cell enumerator: maps a box onto a centred square grid and
// emits the index of every overlapped cell, row-major. Depends on bgce_pkg, bgce_div.
// After request acceptance the first cell needs four divisions in the one shared
// divider, span setup and the output register.
// Throughput: one cell per cycle while the output is not stalled, up to 64 cells;
// the next request is taken only after the last cell of the box has been issued.
// Inverted boxes finish at acceptance. Reset: synchronous; grid_size 64, square_size 32.
`default_nettype none
module box_to_grid_cell_enumerator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [bgce_pkg::COORD_W-1:0]         req_min_x,
   input  wire logic [bgce_pkg::COORD_W-1:0]         req_min_y,
   input  wire logic [bgce_pkg::COORD_W-1:0]         req_max_x,
   input  wire logic [bgce_pkg::COORD_W-1:0]         req_max_y,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [bgce_pkg::IDX_W-1:0]           rsp_cell_index,
   output logic                                      rsp_out_of_grid,
   output logic                                      rsp_truncated,
   output logic                                      rsp_last,
   // register write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bgce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bgce_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bgce_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;   // launch a division
   localparam logic [2:0] ST_WAIT  = 3'd2;   // wait for the quotient
   localparam logic [2:0] ST_SPAN  = 3'd3;   // clamp spans
   localparam logic [2:0] ST_EMIT  = 3'd4;   // walk the cells

   localparam logic [1:0] SEL_MIN_X = 2'd0;
   localparam logic [1:0] SEL_MAX_X = 2'd1;
   localparam logic [1:0] SEL_MIN_Y = 2'd2;
   localparam logic [1:0] SEL_MAX_Y = 2'd3;

   // Registers
   logic [GRID_W-1:0]  grid_ff, grid_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [2:0]         state_ff, state_in;
   logic [1:0]         sel_ff, sel_in;
   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [DVD_W-1:0]   c0_ff, c0_in, c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [DVD_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [SPAN_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;   // span minus one
   logic [SPAN_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic               trunc_ff, trunc_in;
   logic               vld_ff, vld_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               oog_ff, oog_in;
   logic               otr_ff, otr_in;
   logic               last_ff, last_in;

   // Combinational
   logic [GRID_W-1:0]  g_eff;
   logic [SQ_W-1:0]    s_eff;
   logic               accept, inverted, slot_free, cell_last, outside;
   logic [COORD_W-1:0] sel_coord;
   logic [DVD_W-1:0]   dvd;
   logic               div_start;
   div_stat_type       div_stat;
   logic [DVD_W-1:0]   quo;
   logic [DVD_W-1:0]   dx, dy;
   logic               wide_x, wide_y;
   logic [CELL_W+GRID_W-1:0] prod;

   // Effective register values: zero acts as one, grid clamps to MAX_GRID
   always_comb begin
      g_eff = grid_ff;
      if (grid_ff == '0) begin
         g_eff = GRID_W'(1);
      end else if (grid_ff > GRID_W'(MAX_GRID)) begin
         g_eff = GRID_W'(MAX_GRID);
      end
      s_eff = (sq_ff == '0) ? SQ_W'(1) : sq_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign inverted  = ($signed(req_max_x) < $signed(req_min_x)) ||
                      ($signed(req_max_y) < $signed(req_min_y));
   assign csr_ready = 1'b1;
   assign slot_free = !vld_ff || !rsp_stall;

   always_comb begin
      case (sel_ff)
         SEL_MIN_X: sel_coord = x0_ff;
         SEL_MAX_X: sel_coord = x1_ff;
         SEL_MIN_Y: sel_coord = y0_ff;
         SEL_MAX_Y: sel_coord = y1_ff;
         default:   sel_coord = x0_ff;
      endcase
   end

   // Offset coordinate, sign-extended coordinate plus nonnegative offset
   assign dvd       = {sel_coord[COORD_W-1], sel_coord} + DVD_W'(off_ff);
   assign div_start = (state_ff == ST_START);

   bgce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (s_eff),
      .stat     (div_stat),
      .quotient (quo)
   );

   // Span clamp; floor is monotonic so both differences are nonnegative
   assign dx     = c1_ff - c0_ff;
   assign dy     = r1_ff - r0_ff;
   assign wide_x = dx >= DVD_W'(MAX_SPAN);
   assign wide_y = dy >= DVD_W'(MAX_SPAN);

   // Current cell
   assign outside   = row_ff[DVD_W-1] || col_ff[DVD_W-1] ||
                      ($signed(row_ff) >= $signed(DVD_W'(g_eff))) ||
                      ($signed(col_ff) >= $signed(DVD_W'(g_eff)));
   assign prod      = row_ff[CELL_W-1:0] * g_eff;
   assign cell_last = (cx_ff == nx_ff) && (cy_ff == ny_ff);

   always_comb begin
      grid_in  = grid_ff;
      sq_in    = sq_ff;
      state_in = state_ff;
      sel_in   = sel_ff;
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      off_in = off_ff;
      c0_in = c0_ff; c1_in = c1_ff; r0_in = r0_ff; r1_in = r1_ff;
      col_in = col_ff; row_in = row_ff;
      nx_in = nx_ff; ny_in = ny_ff; cx_in = cx_ff; cy_in = cy_ff;
      trunc_in = trunc_ff;
      vld_in   = vld_ff && rsp_stall;
      idx_in   = idx_ff;
      oog_in   = oog_ff;
      otr_in   = otr_ff;
      last_in  = last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_SIZE:   grid_in = csr_data[GRID_W-1:0];
            CSR_SQUARE_SIZE: sq_in   = csr_data[SQ_W-1:0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && !inverted) begin
               x0_in    = req_min_x;
               x1_in    = req_max_x;
               y0_in    = req_min_y;
               y1_in    = req_max_y;
               off_in   = g_eff[GRID_W-1:1] * s_eff;
               sel_in   = SEL_MIN_X;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               case (sel_ff)
                  SEL_MIN_X: c0_in = quo;
                  SEL_MAX_X: c1_in = quo;
                  SEL_MIN_Y: r0_in = quo;
                  SEL_MAX_Y: r1_in = quo;
                  default:   ;
               endcase
               sel_in   = sel_ff + 2'd1;
               state_in = (sel_ff == SEL_MAX_Y) ? ST_SPAN : ST_START;
            end
         end
         ST_SPAN: begin
            nx_in    = wide_x ? SPAN_W'(MAX_SPAN - 1) : dx[SPAN_W-1:0];
            ny_in    = wide_y ? SPAN_W'(MAX_SPAN - 1) : dy[SPAN_W-1:0];
            trunc_in = wide_x || wide_y;
            col_in   = c0_ff;
            row_in   = r0_ff;
            cx_in    = '0;
            cy_in    = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               vld_in  = 1'b1;
               idx_in  = outside ? '0 : IDX_W'(prod + (CELL_W+GRID_W)'(col_ff[CELL_W-1:0]));
               oog_in  = outside;
               otr_in  = trunc_ff;
               last_in = cell_last;
               if (cell_last) begin
                  state_in = ST_IDLE;
               end else if (cx_ff == nx_ff) begin
                  cx_in  = '0;
                  col_in = c0_ff;
                  cy_in  = cy_ff + SPAN_W'(1);
                  row_in = row_ff + DVD_W'(1);
               end else begin
                  cx_in  = cx_ff + SPAN_W'(1);
                  col_in = col_ff + DVD_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff  <= GRID_RESET;
         sq_ff    <= SQ_RESET;
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         grid_ff  <= grid_in;
         sq_ff    <= sq_in;
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      sel_ff   <= sel_in;
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      off_ff   <= off_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      trunc_ff <= trunc_in;
      idx_ff   <= idx_in;
      oog_ff   <= oog_in;
      otr_ff   <= otr_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_cell_index  = idx_ff;
   assign rsp_out_of_grid = oog_ff;
   assign rsp_truncated   = otr_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// File: dv/tb_box_to_grid_cell_enumerator_core.sv
// Self-checking testbench for box_to_grid_cell_enumerator_core: drives boxes and CSR writes,
// predicts every emitted cell and compares it field by field with the result channel.
// Depends on bgce_pkg and the core RTL; stands alone otherwise.
`default_nettype none
module tb_box_to_grid_cell_enumerator_core;
   import bgce_pkg::*;

   // Unmapped CSR slots; writes there must leave both registers alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   localparam int  SETTLE_CYCLES = 200;   // outlasts a box's four divisions and span setup plus 64 cells
   localparam int  HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int  QUIET_LIMIT   = 2000;  // watchdog: cycles with no handshake at all
   localparam longint COORD_MIN  = -(longint'(1) << (COORD_W - 1));
   localparam longint COORD_MAX  = (longint'(1) << (COORD_W - 1)) - 1;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic             off_grid;
      logic             trunc;
      logic             last;
   } cell_type;

   // Clock, reset and every DUT input start at known values
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_min_x = '0;
   logic [COORD_W-1:0]    req_min_y = '0;
   logic [COORD_W-1:0]    req_max_x = '0;
   logic [COORD_W-1:0]    req_max_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [IDX_W-1:0]      rsp_cell_index;
   logic                  rsp_out_of_grid;
   logic                  rsp_truncated;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the two CSRs, updated on every accepted write
   logic [GRID_W-1:0]     grid_shadow   = GRID_RESET;
   logic [SQ_W-1:0]       square_shadow = SQ_RESET;

   cell_type              expected_cells[$];
   cell_type              want;
   int                    mismatches    = 0;
   int                    quiet_cycles  = 0;
   int                    hold_requests = 0;   // bumped by the pressure test
   int                    hold_served   = 0;   // bumped by the receiver when done
   bit                    tx_idling     = 1'b1;
   bit                    rx_idling     = 1'b1;

   box_to_grid_cell_enumerator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_min_x       (req_min_x),
      .req_min_y       (req_min_y),
      .req_max_x       (req_max_x),
      .req_max_y       (req_max_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_out_of_grid (rsp_out_of_grid),
      .rsp_truncated   (rsp_truncated),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Cell prediction
   // ------------------------------------------------------------------

   // Grid size 0 behaves as 1, anything past MAX_GRID saturates.
   function automatic longint eff_grid();
      longint g;
      g = grid_shadow;
      if (g < 1) g = 1;
      if (g > MAX_GRID) g = MAX_GRID;
      return g;
   endfunction

   // Square size 0 behaves as 1.
   function automatic longint eff_square();
      return (square_shadow == '0) ? 1 : longint'(square_shadow);
   endfunction

   // Division rounding toward minus infinity
   function automatic longint div_floor(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // Queue every cell a box should produce, row-major, first MAX_SPAN per axis.
   task automatic predict_cells(input logic [COORD_W-1:0] x0r, y0r, x1r, y1r);
      longint   g, s, off, x0, y0, x1, y1, c0, c1, r0, r1, nx, ny;
      bit       trunc;
      int       n, total;
      cell_type exp_item;
      g  = eff_grid();
      s  = eff_square();
      x0 = longint'($signed(x0r));
      y0 = longint'($signed(y0r));
      x1 = longint'($signed(x1r));
      y1 = longint'($signed(y1r));
      trunc = 1'b0;
      n = 0;
      // inverted box: nothing at all
      if (x1 < x0 || y1 < y0) return;
      // grid centred on the origin: shift by half the grid before dividing
      off = (g / 2) * s;
      c0  = div_floor(x0 + off, s);
      c1  = div_floor(x1 + off, s);
      r0  = div_floor(y0 + off, s);
      r1  = div_floor(y1 + off, s);
      nx  = c1 - c0 + 1;
      ny  = r1 - r0 + 1;
      if (nx > MAX_SPAN) begin
         nx = MAX_SPAN;
         trunc = 1'b1;
      end
      if (ny > MAX_SPAN) begin
         ny = MAX_SPAN;
         trunc = 1'b1;
      end
      total = int'(nx * ny);
      for (longint r = r0; r < r0 + ny; r++) begin
         for (longint c = c0; c < c0 + nx; c++) begin
            exp_item.off_grid = (r < 0 || r >= g || c < 0 || c >= g);
            exp_item.index    = exp_item.off_grid ? '0 : IDX_W'(r * g + c);
            exp_item.trunc    = trunc;
            exp_item.last     = (n == total - 1);
            expected_cells    = {expected_cells, exp_item};
            n++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: result check, CSR shadow, prediction on request accept.
   // Results are popped before new requests are pushed so a stray
   // result can never match a box accepted on the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected cell idx %0d oog %0b trunc %0b last %0b",
                           $realtime, rsp_cell_index, rsp_out_of_grid, rsp_truncated,
                           rsp_last);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_cell_index !== want.index || rsp_out_of_grid !== want.off_grid ||
                   rsp_truncated !== want.trunc || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: cell mismatch exp idx %0d oog %0b trunc %0b last %0b,",
                               " got idx %0d oog %0b trunc %0b last %0b"},
                              $realtime, want.index, want.off_grid, want.trunc, want.last,
                              rsp_cell_index, rsp_out_of_grid, rsp_truncated, rsp_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_SIZE:   grid_shadow   = csr_data[GRID_W-1:0];
               CSR_SQUARE_SIZE: square_shadow = csr_data[SQ_W-1:0];
               default: ;   // unmapped slot, ignored
            endcase
         end
         if (req_valid && !req_stall)
            predict_cells(req_min_x, req_min_y, req_max_x, req_max_y);
      end
   end

   // Watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Gap lengths: mostly short, some medium, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stall bursts, plus a counted long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
            rsp_stall <= 1'b0;
         end else if (rx_idling && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap()) @(posedge clock);
            rsp_stall <= 1'b0;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   function automatic logic [COORD_W-1:0] to_coord(longint v);
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > COORD_MAX) v = COORD_MAX;
      return v[COORD_W-1:0];
   endfunction

   // One box request; valid stays up across back-to-back requests.
   task automatic send_box(input longint x0, y0, x1, y1);
      int gap;
      gap = (tx_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_min_x <= to_coord(x0);
      req_min_y <= to_coord(y0);
      req_max_x <= to_coord(x1);
      req_max_y <= to_coord(y1);
      do @(posedge clock); while (req_stall);
   endtask

   // CSR write; only issued while the core is drained
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, let the monitor log the last request, wait for all
   // predicted cells, then let any empty box finish
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random box sized against the current grid: mostly small spans near
   // or on the grid, some wide ones, some inverted, some full-range noise.
   task automatic random_box();
      longint g, s, reach, cx, cy, wx, wy, x0, y0, x1, y1;
      int     kind;
      g = eff_grid();
      s = eff_square();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         send_box(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                  longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
         return;
      end
      reach = (g / 2) * s + 2 * s;
      cx = longint'($urandom_range(0, 32'(2 * reach))) - reach;
      cy = longint'($urandom_range(0, 32'(2 * reach))) - reach;
      wx = (($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7)) * s
           + $urandom_range(0, 32'(s - 1));
      wy = (($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7)) * s
           + $urandom_range(0, 32'(s - 1));
      x0 = cx - wx / 2;
      y0 = cy - wy / 2;
      x1 = x0 + wx;
      y1 = y0 + wy;
      if (kind < 20) begin
         // inverted in one axis
         if (kind[0]) x1 = x0 - 1 - $urandom_range(0, 32'(s));
         else         y1 = y0 - 1 - $urandom_range(0, 32'(s));
      end
      send_box(x0, y0, x1, y1);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values 64 x 32: the grid covers -1024 .. 1023 on both axes
   task automatic test_reset_config();
      send_box(0, 0, 5, 5);                            // one cell at the centre
      send_box(0, -10, 70, 20);                        // 3 x 2 cells
      send_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX); // whole range, clipped, off grid
      send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX); // point at the top corner
      send_box(10, 0, 9, 0);                           // inverted in x
      send_box(0, 10, 0, 9);                           // inverted in y
      send_box(-1, -33, -1, -1);                       // negative, floor rounding
      send_box(-1040, 1000, -1000, 1030);              // straddles the grid edge
      wait_drain();
   endtask

   // Span limit: exactly MAX_SPAN cells versus one more, per axis
   task automatic test_span_limit();
      send_box(0, 0, 255, 0);                          // 8 columns, not clipped
      send_box(0, 0, 256, 0);                          // 9 columns, clipped
      send_box(0, 0, 0, 256);                          // 9 rows, clipped
      send_box(-300, -300, 300, 300);                  // clipped both ways
      wait_drain();
   endtask

   // Register extremes, zero values and unmapped slots
   task automatic test_csr_extremes();
      csr_write(CSR_GRID_SIZE, 16'd1);
      csr_write(CSR_SQUARE_SIZE, 16'd1);
      send_box(0, 0, 0, 0);                            // the single in-grid cell
      send_box(-1, -1, 1, 1);                          // 3 x 3, centre only on grid
      wait_drain();
      csr_write(CSR_GRID_SIZE, 16'd0);                 // behaves as 1
      csr_write(CSR_SQUARE_SIZE, 16'd0);               // behaves as 1
      send_box(-1, 0, 1, 1);
      wait_drain();
      csr_write(CSR_SPARE_LO, 16'hFFFF);               // must be dropped
      csr_write(CSR_SPARE_HI, 16'h1234);
      send_box(0, 0, 0, 0);
      wait_drain();
      csr_write(CSR_GRID_SIZE, 16'hFFFF);              // 511, saturates to MAX_GRID
      csr_write(CSR_SQUARE_SIZE, 16'hFFFF);
      send_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_box(-65536, -1, 65535, 0);
      wait_drain();
      csr_write(CSR_GRID_SIZE, 16'd256);               // largest legal grid
      csr_write(CSR_SQUARE_SIZE, 16'd3);
      send_box(-384, -384, -370, -360);                // bottom-left corner cells
      send_box(370, 380, 383, 383);                    // top-right corner cells
      wait_drain();
   endtask

   // Receiver holds off long enough that the core backs up into req_stall
   task automatic test_backpressure();
      csr_write(CSR_GRID_SIZE, 16'd20);
      csr_write(CSR_SQUARE_SIZE, 16'd10);
      tx_idling = 1'b0;
      hold_requests++;
      for (int i = 0; i < 6; i++)
         send_box(-20 + 5 * i, -15, 15 + 5 * i, 15);
      tx_idling = 1'b1;
      wait_drain();
   endtask

   // Random configurations, each followed by a batch of random boxes
   task automatic test_random_boxes();
      logic [CSR_DATA_W-1:0] grid_val, square_val;
      int                    pick;
      for (int phase = 0; phase < 5; phase++) begin
         pick = $urandom_range(0, 5);
         grid_val = (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom_range(257, 511)) : 16'($urandom_range(1, 256));
         // junk in the bits above the grid field must be ignored
         grid_val[CSR_DATA_W-1:GRID_W] = (CSR_DATA_W - GRID_W)'($urandom);
         pick = $urandom_range(0, 9);
         square_val = (pick == 0) ? 16'd0 :
                      (pick < 3)  ? 16'($urandom_range(65, 65535)) : 16'($urandom_range(1, 64));
         csr_write(CSR_GRID_SIZE, grid_val);
         csr_write(CSR_SQUARE_SIZE, square_val);
         // one phase runs with no idling on either side
         tx_idling = (phase != 2);
         rx_idling = (phase != 2);
         for (int i = 0; i < 27; i++)
            random_box();
         wait_drain();
      end
      tx_idling = 1'b1;
      rx_idling = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_span_limit();
      test_csr_extremes();
      test_backpressure();
      test_random_boxes();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
